@@ design/kfi_pkg.sv @@
`timescale 1ns / 1ps
// kfi_pkg: shared constants and types for the keyframe interpolator
// no dependencies

package kfi_pkg;

  localparam int unsigned FrameW = 24;
  localparam int unsigned PosW   = 20;
  localparam int unsigned ScaleW = 24;
  localparam int unsigned AngW   = 15;
  localparam int unsigned CountW = 7;
  localparam int unsigned FracW  = 17;

  localparam logic [AngW-1:0] FullTurn = 15'd23040;
  localparam logic [AngW-1:0] HalfTurn = 15'd11520;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StScan  = 7'b0000010,
    StLoad  = 7'b0000100,
    StDiv   = 7'b0001000,
    StMul   = 7'b0010000,
    StFin   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

endpackage

@@ design/keyframe_interpolator.sv @@
`timescale 1ns / 1ps
// keyframe_interpolator: keyframe table with linear interpolation
// depends on kfi_pkg
// a write is stored as it is accepted; a query scans up to n keys (one table read a cycle),
// loads both keys, runs the restoring division for the fraction and then the shared multiplier,
// then finishes; when the left key's frame is not below the right key's it skips to the
// output with the left key; the result is held until taken; one request at a time
// reset clears control state and key_count to 1; the key table is undefined until written

module keyframe_interpolator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         operation_i,
  input  logic [5:0]                   key_index_i,
  input  logic [kfi_pkg::FrameW-1:0]   frame_i,
  input  logic signed [kfi_pkg::PosW-1:0] in_pos_x_i,
  input  logic signed [kfi_pkg::PosW-1:0] in_pos_y_i,
  input  logic [kfi_pkg::ScaleW-1:0]   in_scale_i,
  input  logic [kfi_pkg::AngW-1:0]     in_angle_i,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [kfi_pkg::PosW-1:0] out_pos_x_o,
  output logic signed [kfi_pkg::PosW-1:0] out_pos_y_o,
  output logic [kfi_pkg::ScaleW-1:0]   out_scale_o,
  output logic [kfi_pkg::AngW-1:0]     out_angle_o,
  output logic                         off_key_o,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [kfi_pkg::CountW-1:0]   cfg_data
);
  import kfi_pkg::*;

  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned EntW = FrameW + 2*PosW + ScaleW + AngW;
  localparam logic [4:0]  DivInit = 5'd17;

  logic [EntW-1:0] mem [MAX_KEYS];
  logic [EntW-1:0] rd_q;

  state_e state_q, state_d;
  logic [CountW-1:0] count_q;
  logic [IdxW:0]     scan_q;
  logic [IdxW:0]     n_lim;
  logic              rvalid_q, found_q, done_q;
  logic [IdxW-1:0]   li_q, ri_q;
  logic [FrameW-1:0] fq_q;

  // entries: left and right keys
  logic [EntW-1:0] lk_q, rk_q;
  logic            load_r_q;

  // divider
  logic [FrameW:0]  rem_q;
  logic [FrameW-1:0] num_q, den_q;
  logic [FracW-1:0] t_q;
  logic [4:0]       cnt_q;

  // shared multiplier
  logic [1:0]       mi_q;
  logic [ScaleW-1:0] mag_q [4];
  logic              neg_q [4];
  logic [ScaleW-1:0] step_q [4];

  logic signed [PosW-1:0] ox_q, oy_q;
  logic [ScaleW-1:0] os_q;
  logic [AngW-1:0]   oa_q;
  logic              off_q;

  wire in_acc = in_valid && !in_stall;
  wire [AngW-1:0] ang_in = (in_angle_i >= FullTurn) ? in_angle_i - FullTurn : in_angle_i;

  assign in_stall  = (state_q != StIdle);
  assign cfg_ready = (state_q == StIdle);
  assign out_valid = (state_q == StOut);

  always_comb begin
    if (count_q == '0) n_lim = (IdxW+1)'(1);
    else if ({{(32-CountW){1'b0}}, count_q} > MAX_KEYS) n_lim = (IdxW+1)'(MAX_KEYS);
    else n_lim = (IdxW+1)'(count_q);
  end

  function automatic logic [FrameW-1:0] kf(input logic [EntW-1:0] e);
    kf = e[EntW-1 -: FrameW];
  endfunction
  function automatic logic signed [PosW-1:0] kx(input logic [EntW-1:0] e);
    kx = e[2*PosW+ScaleW+AngW-1 -: PosW];
  endfunction
  function automatic logic signed [PosW-1:0] ky(input logic [EntW-1:0] e);
    ky = e[PosW+ScaleW+AngW-1 -: PosW];
  endfunction
  function automatic logic [ScaleW-1:0] ks(input logic [EntW-1:0] e);
    ks = e[ScaleW+AngW-1 -: ScaleW];
  endfunction
  function automatic logic [AngW-1:0] ka(input logic [EntW-1:0] e);
    ka = e[AngW-1:0];
  endfunction

  logic [FrameW-1:0] dnum;
  assign dnum = fq_q - kf(lk_q);

  logic [IdxW-1:0] rd_addr;
  always_comb begin
    rd_addr = scan_q[IdxW-1:0];
    if (state_q == StLoad) rd_addr = load_r_q ? ri_q : li_q;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && operation_i == OpWrite &&
        {{(32-6){1'b0}}, key_index_i} < MAX_KEYS)
      mem[IdxW'(key_index_i)] <= {frame_i, in_pos_x_i, in_pos_y_i, in_scale_i, ang_in};
    rd_q <= mem[rd_addr];
  end

  // shared multiplier operands
  logic [ScaleW+FracW-1:0] prod;
  assign prod = mag_q[mi_q] * t_q;

  logic signed [PosW:0] dx, dy;
  logic signed [ScaleW:0] ds;
  logic signed [AngW:0] da;
  logic [AngW-1:0] up;
  logic go_up;
  always_comb begin
    dx = (PosW+1)'(kx(rk_q)) - (PosW+1)'(kx(lk_q));
    dy = (PosW+1)'(ky(rk_q)) - (PosW+1)'(ky(lk_q));
    ds = {1'b0, ks(rk_q)} - {1'b0, ks(lk_q)};
    da = {1'b0, ka(rk_q)} - {1'b0, ka(lk_q)};
    up = da[AngW] ? AngW'(da + {1'b0, FullTurn}) : da[AngW-1:0];
    go_up = (up <= HalfTurn);
  end

  logic [AngW:0] asum;
  always_comb begin
    if (neg_q[3]) begin
      asum = {1'b0, ka(lk_q)} - {1'b0, step_q[3][AngW-1:0]};
      if (asum[AngW]) asum = asum + {1'b0, FullTurn};
    end else begin
      asum = {1'b0, ka(lk_q)} + {1'b0, step_q[3][AngW-1:0]};
      if (asum >= {1'b0, FullTurn}) asum = asum - {1'b0, FullTurn};
    end
  end

  logic [FrameW:0] rem_sh;
  assign rem_sh = {rem_q[FrameW-1:0], num_q[FrameW-1]};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc && operation_i == OpQuery) state_d = StScan;
      StScan: if (done_q) state_d = StLoad;
      StLoad: if (load_r_q && rvalid_q) state_d = StDiv;
      StDiv:  if (kf(lk_q) >= kf(rk_q)) state_d = StOut;
              else if (cnt_q == 5'd0) state_d = StMul;
      StMul:  if (mi_q == 2'd3) state_d = StFin;
      StFin:  state_d = StOut;
      StOut:  if (!out_stall) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= CountW'(1);
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) count_q <= cfg_data;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        scan_q <= '0; rvalid_q <= 1'b0; found_q <= 1'b0; done_q <= 1'b0;
        li_q <= '0; ri_q <= '0; fq_q <= frame_i; load_r_q <= 1'b0;
      end
      StScan: begin
        // rd_q holds slot scan_q-1 once rvalid_q is set
        if (scan_q < n_lim) scan_q <= scan_q + 1'b1;
        rvalid_q <= (scan_q < n_lim) && !done_q;
        if (rvalid_q && !done_q) begin
          ri_q <= IdxW'(scan_q - 1'b1);
          if (kf(rd_q) <= fq_q) begin
            li_q <= IdxW'(scan_q - 1'b1); found_q <= 1'b1;
          end else if (!found_q) begin
            li_q <= IdxW'(scan_q - 1'b1);
          end
          if (kf(rd_q) >= fq_q) done_q <= 1'b1;
        end else if (!rvalid_q && scan_q == n_lim) begin
          done_q <= 1'b1;
        end
      end
      StLoad: begin
        rvalid_q <= !rvalid_q;
        if (rvalid_q) begin
          if (!load_r_q) lk_q <= rd_q;
          else rk_q <= rd_q;
          load_r_q <= 1'b1;
        end
        cnt_q <= DivInit;
      end
      StDiv: begin
        if (cnt_q == DivInit) begin
          // the upper quotient bits are zero, so start with all but the last numerator bit
          num_q <= {dnum[0], (FrameW-1)'(0)};
          den_q <= kf(rk_q) - kf(lk_q);
          rem_q <= {2'b00, dnum[FrameW-1:1]}; t_q <= '0;
          cnt_q <= cnt_q - 1'b1;
          mag_q[0] <= ScaleW'(dx[PosW] ? -dx : dx); neg_q[0] <= dx[PosW];
          mag_q[1] <= ScaleW'(dy[PosW] ? -dy : dy); neg_q[1] <= dy[PosW];
          mag_q[2] <= ScaleW'(ds[ScaleW] ? -ds : ds); neg_q[2] <= ds[ScaleW];
          mag_q[3] <= ScaleW'(go_up ? up : FullTurn - up); neg_q[3] <= !go_up;
          mi_q <= '0;
        end else begin
          // restoring division of num * 2^16 by den, one quotient bit a cycle
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            t_q <= {t_q[FracW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            t_q <= {t_q[FracW-2:0], 1'b0};
          end
          num_q <= {num_q[FrameW-2:0], 1'b0};
          if (cnt_q != 5'd0) cnt_q <= cnt_q - 1'b1;
        end
        ox_q <= kx(lk_q); oy_q <= ky(lk_q); os_q <= ks(lk_q); oa_q <= ka(lk_q);
        off_q <= (kf(lk_q) != fq_q) && (kf(rk_q) != fq_q);
      end
      StMul: begin
        step_q[mi_q] <= prod[ScaleW+15:16];
        mi_q <= mi_q + 1'b1;
      end
      StFin: begin
        ox_q <= neg_q[0] ? ox_q - PosW'(step_q[0]) : ox_q + PosW'(step_q[0]);
        oy_q <= neg_q[1] ? oy_q - PosW'(step_q[1]) : oy_q + PosW'(step_q[1]);
        os_q <= neg_q[2] ? os_q - step_q[2] : os_q + step_q[2];
        oa_q <= asum[AngW-1:0];
      end
      StOut: ;
      default: ;
    endcase
  end

  assign out_pos_x_o = ox_q;
  assign out_pos_y_o = oy_q;
  assign out_scale_o = os_q;
  assign out_angle_o = oa_q;
  assign off_key_o   = off_q;

  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall)
    else $error("request taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(out_angle_o)))
    else $error("result lost under stall");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_angle_o < FullTurn))
    else $error("angle out of range");

endmodule

@@ tb/keyframe_interpolator_tb.sv @@
`timescale 1ns / 1ps
// keyframe_interpolator_tb: self-checking bench for the keyframe interpolator
// depends on kfi_pkg and keyframe_interpolator; query results are checked against a predictor
// of the table scan and interpolation that follows key writes and key_count changes

class kfi_scoreboard;
  logic [kfi_pkg::FrameW-1:0] key_frame [64];
  logic [kfi_pkg::PosW-1:0]   key_x [64];
  logic [kfi_pkg::PosW-1:0]   key_y [64];
  logic [kfi_pkg::ScaleW-1:0] key_scale [64];
  logic [kfi_pkg::AngW-1:0]   key_ang [64];
  int unsigned                scan_len;
  logic [79:0]                pending_pose [$];
  int                         errors;

  function new();
    scan_len = 1;
    errors = 0;
  endfunction

  function void set_count(logic [kfi_pkg::CountW-1:0] v);
    scan_len = (v == 0) ? 1 : ((v > 64) ? 64 : v);
  endfunction

  function longint step_of(longint a, longint b, longint t);
    longint d;
    longint m;
    d = b - a;
    m = (d < 0) ? -d : d;
    m = (m * t) >>> 16;
    return (d < 0) ? a - m : a + m;
  endfunction

  // accepted input request: update table or predict a pose
  function void note_request(logic op, logic [5:0] idx, logic [23:0] f, logic [19:0] x,
                             logic [19:0] y, logic [23:0] s, logic [14:0] a);
    int unsigned li, ri, up, mag, stp;
    bit found;
    longint px, py, sc, t, an;
    logic [19:0] ox, oy;
    logic [23:0] os;
    logic [14:0] oa;
    logic off;
    li = 0;
    ri = 0;
    found = 0;
    if (op == kfi_pkg::OpWrite) begin
      key_frame[idx] = f;
      key_x[idx] = x;
      key_y[idx] = y;
      key_scale[idx] = s;
      key_ang[idx] = (a >= 23040) ? 15'(a - 23040) : a;
      return;
    end
    for (int i = 0; i < scan_len; i++) begin
      if (key_frame[i] <= f) begin
        li = i;
        ri = i;
        found = 1;
      end
      if (key_frame[i] >= f) begin
        ri = i;
        if (!found) li = i;
        break;
      end
    end
    off = (key_frame[li] != f) && (key_frame[ri] != f);
    px = $signed(key_x[li]);
    py = $signed(key_y[li]);
    sc = key_scale[li];
    an = key_ang[li];
    if (key_frame[li] < key_frame[ri]) begin
      t = ((longint'(f) - key_frame[li]) << 16) / (longint'(key_frame[ri]) - key_frame[li]);
      px = step_of(px, $signed(key_x[ri]), t);
      py = step_of(py, $signed(key_y[ri]), t);
      sc = step_of(sc, key_scale[ri], t);
      up = (key_ang[ri] >= key_ang[li]) ? key_ang[ri] - key_ang[li]
                                         : key_ang[ri] + 23040 - key_ang[li];
      mag = (up <= 11520) ? up : 23040 - up;
      stp = 32'((longint'(mag) * t) >> 16);
      an = (up <= 11520) ? an + stp : an - stp;
      if (an < 0) an += 23040;
      if (an >= 23040) an -= 23040;
    end
    ox = px[19:0];
    oy = py[19:0];
    os = sc[23:0];
    oa = an[14:0];
    pending_pose.push_back({ox, oy, os, oa, off});
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  task check_pose(logic [19:0] x, logic [19:0] y, logic [23:0] s, logic [14:0] a,
                  logic off);
    logic [79:0] e;
    if (pending_pose.size() == 0) begin
      report("unexpected result", x, 0);
      return;
    end
    e = pending_pose.pop_front();
    if (x !== e[79:60]) report("pos_x", x, e[79:60]);
    if (y !== e[59:40]) report("pos_y", y, e[59:40]);
    if (s !== e[39:16]) report("scale", s, e[39:16]);
    if (a !== e[15:1]) report("angle", a, e[15:1]);
    if (off !== e[0]) report("off_key", off, e[0]);
  endtask
endclass

module keyframe_interpolator_tb;
  import kfi_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  logic op = 0;
  logic [5:0] idx = 0;
  logic [FrameW-1:0] frame = 0;
  logic signed [PosW-1:0] px = 0, py = 0;
  logic [ScaleW-1:0] sc = 0;
  logic [AngW-1:0] ang = 0;
  logic out_valid, out_stall = 0;
  logic signed [PosW-1:0] ox, oy;
  logic [ScaleW-1:0] osc;
  logic [AngW-1:0] oang;
  logic off;
  logic cfg_valid = 0, cfg_ready;
  logic [CountW-1:0] cfg_data = 0;
  int cycles = 0;
  int hold_off = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int unsigned nkeys;
  kfi_scoreboard board;

  keyframe_interpolator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation_i(op), .key_index_i(idx), .frame_i(frame),
    .in_pos_x_i(px), .in_pos_y_i(py), .in_scale_i(sc), .in_angle_i(ang),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x_o(ox), .out_pos_y_o(oy), .out_scale_o(osc), .out_angle_o(oang),
    .off_key_o(off),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("** keyframe_interpolator: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= 600;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if ((cycles / 200) % 3 == 0) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
    if (rst_n && out_valid && !out_stall)
      board.check_pose(ox, oy, osc, oang, off);
  end

  task automatic send(logic o, logic [5:0] i, logic [23:0] f, logic [19:0] x, logic [19:0] y,
                      logic [23:0] s, logic [14:0] a);
    op <= o;
    idx <= i;
    frame <= f;
    px <= x;
    py <= y;
    sc <= s;
    ang <= a;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_request(o, i, f, x, y, s, a);
  endtask

  task automatic pause();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_pose.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_count(logic [CountW-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.set_count(v);
  endtask

  task automatic write_key(int k, logic [23:0] f);
    send(OpWrite, 6'(k), f, 20'($urandom), 20'($urandom), 24'($urandom),
         15'($urandom_range(0, 32767)));
  endtask

  // sorted keys in the first n slots with random content, frames spaced randomly
  task automatic load_table(int n, int gap);
    logic [23:0] f;
    f = 24'($urandom_range(0, 1000));
    for (int k = 0; k < n; k++) begin
      write_key(k, f);
      if ($urandom_range(0, 7) == 0) pause();
      f = f + 24'($urandom_range(0, gap));
    end
  endtask

  task automatic random_query();
    logic [23:0] f;
    int k;
    k = $urandom_range(0, nkeys - 1);
    case ($urandom_range(0, 4))
      0: f = board.key_frame[k];
      1: f = board.key_frame[k] + 24'($urandom_range(0, 300));
      2: f = 24'($urandom);
      3: f = 0;
      default: f = board.key_frame[k] - 24'($urandom_range(0, 300));
    endcase
    send(OpQuery, 6'($urandom), f, 20'($urandom), 20'($urandom), 24'($urandom),
         15'($urandom));
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: fill every slot, then extremes and angle wrap cases
    write_count(7'd0);
    for (int k = 0; k < 64; k++) write_key(k, 24'(k * 10));
    send(OpWrite, 0, 0, 20'h80000, 20'h7FFFF, 24'h0, 15'd0);
    send(OpWrite, 1, 10, 20'h7FFFF, 20'h80000, 24'hFFFFFF, 15'd11520);
    send(OpWrite, 2, 20, 20'h00001, 20'hFFFFF, 24'h000001, 15'd23039);
    send(OpWrite, 3, 30, 20'hFFFFF, 20'h00001, 24'h7FFFFF, 15'd32767);
    send(OpWrite, 4, 30, 20'h00010, 20'h00000, 24'h123456, 15'd100);
    send(OpWrite, 5, 24'hFFFFFF, 20'h00000, 20'h00000, 24'h0, 15'd23040);
    send(OpQuery, 0, 5, 0, 0, 0, 0);
    drain();
    write_count(7'd127);
    send(OpQuery, 0, 0, 0, 0, 0, 0);
    send(OpQuery, 0, 5, 0, 0, 0, 0);
    send(OpQuery, 0, 10, 0, 0, 0, 0);
    send(OpQuery, 0, 17, 0, 0, 0, 0);
    send(OpQuery, 0, 25, 0, 0, 0, 0);
    send(OpQuery, 0, 30, 0, 0, 0, 0);
    send(OpQuery, 0, 24'hFFFFFE, 0, 0, 0, 0);
    send(OpQuery, 0, 24'hFFFFFF, 0, 0, 0, 0);
    drain();
    write_count(7'd64);
    send(OpQuery, 0, 24'hFFFFFF, 0, 0, 0, 0);
    drain();

    // random phases with different key counts
    for (int ph = 0; ph < 6; ph++) begin
      nkeys = (ph == 0) ? 1 : (ph == 1) ? 64 : $urandom_range(2, 20);
      load_table(nkeys, (ph % 2) ? 50 : 100000);
      drain();
      write_count((ph == 3) ? 7'd100 : 7'(nkeys));
      for (int q = 0; q < 40; q++) begin
        if (ph == 2 && q == 10) hold_req <= hold_req + 1;
        random_query();
        if ($urandom_range(0, 3) == 0) pause();
      end
      drain();
    end

    // unsorted table
    nkeys = 8;
    for (int k = 0; k < 8; k++) write_key(k, 24'($urandom_range(0, 400)));
    drain();
    write_count(7'd8);
    for (int q = 0; q < 30; q++) random_query();
    drain();

    if (board.errors == 0) begin
      $display("** keyframe_interpolator: PASSED **");
    end else begin
      $display("** keyframe_interpolator: FAILED **");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/kfi_pkg.sv
design/keyframe_interpolator.sv
tb/keyframe_interpolator_tb.sv
